// File: design/tkst_pkg.sv
// Shared types, constants and helpers for the top-k score tracker.
// Used by tkst_cell and top_k_score_tracker_core; depends on nothing.
`default_nettype none

package tkst_pkg;

   // Built depth of the slot row and the most slots ever reported.
   localparam int K_MAX   = 16;
   localparam int OUT_CAP = 16;
   localparam int K_LIMIT = (K_MAX < OUT_CAP) ? K_MAX : OUT_CAP;

   // Field widths.
   localparam int SCORE_W = 32;
   localparam int TAG_W   = 32;
   localparam int RANK_W  = 4;
   localparam int K_CFG_W = 5;
   localparam int CNT_W   = $clog2(K_LIMIT + 1);

   // One incoming request.
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
      logic                      end_of_batch;
   } req_type;

   // One readout result.
   typedef struct packed {
      logic [RANK_W-1:0]         rank;
      logic signed [SCORE_W-1:0] out_score;
      logic [TAG_W-1:0]          out_tag;
      logic                      last;
   } rsp_type;

   // Contents of one slot.
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } slot_type;

   // Commands broadcast to every cell of the row.
   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   // Number of slots in use: zero counts as one, large values saturate.
   function automatic logic [CNT_W-1:0] eff_k(input logic [K_CFG_W-1:0] k);
      logic [CNT_W-1:0] result;
      if (k == '0) begin
         result = CNT_W'(1);
      end else if (k > K_CFG_W'(K_LIMIT)) begin
         result = CNT_W'(K_LIMIT);
      end else begin
         result = CNT_W'(k);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: design/tkst_cell.sv
// One slot of the sorted row: holds a score and tag and trades them with
// its neighbors. Depends on tkst_pkg.
`default_nettype none

module tkst_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tkst_pkg::cell_ctrl_type ctrl,
   input  wire logic                    active,
   input  wire tkst_pkg::slot_type      new_slot,
   input  wire logic                    found_in,
   input  wire tkst_pkg::slot_type      prev_slot,
   input  wire tkst_pkg::slot_type      next_slot,
   output logic                         found_out,
   output tkst_pkg::slot_type           slot
);
   import tkst_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;
   logic     gt;

   // The new score beats this slot only if the slot is in use.
   assign gt        = active && ($signed(new_slot.score) > $signed(slot_ff.score));
   assign found_out = found_in || gt;
   assign slot      = slot_ff;

   // Clear wins, then readout shift, then insertion; otherwise hold.
   always_comb begin
      slot_in = slot_ff;
      priority if (ctrl.clear) begin
         slot_in = '0;
      end else if (ctrl.shift) begin
         slot_in = next_slot;
      end else if (ctrl.insert && active && found_in) begin
         slot_in = prev_slot;
      end else if (ctrl.insert && gt) begin
         slot_in = new_slot;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

// File: design/top_k_score_tracker_core.sv
// Top level of the top-k score tracker: the row of slot cells and the
// readout control. Depends on tkst_pkg and tkst_cell.
`default_nettype none

// An ordinary request is inserted into the sorted row of slots in the cycle
// it is accepted, and a new request can be accepted on every cycle. A
// request marked end of batch is inserted the same way; then the row shifts
// toward slot 0 once per result, one result per cycle into the output
// register while the result side does not stall, for k_in_use results
// (zero reads as one, values above 16 as 16). The request side stalls
// during that readout. The store is cleared in the cycle the last result
// is loaded, so no extra pass follows, and the next request may be taken
// while that result still waits.
module top_k_score_tracker_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tkst_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tkst_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [tkst_pkg::K_CFG_W-1:0]  csr_wr_data
);
   import tkst_pkg::*;

   logic [K_CFG_W-1:0] k_cfg_ff;
   logic [CNT_W-1:0]   k_eff;
   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               req_accept;
   logic               load;
   logic               load_last;
   cell_ctrl_type      ctrl;
   slot_type           new_slot;
   slot_type           slots [K_MAX];
   logic [K_MAX:0]     found;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff <= K_CFG_W'(1);
      end else if (csr_wr_en) begin
         k_cfg_ff <= csr_wr_data;
      end
   end

   assign k_eff      = eff_k(k_cfg_ff);
   assign req_accept = req_valid && !req_stall;
   assign new_slot   = '{score: req_data.score, tag: req_data.tag};

   // A readout step happens when draining and the output register frees up.
   assign load      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign load_last = (cnt_ff + CNT_W'(1)) == k_eff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.end_of_batch) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (load && load_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall   = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.shift  = 1'b0;
      ctrl.clear  = 1'b0;
      cnt_in      = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.insert = req_accept;
            cnt_in      = '0;
         end
         ST_DRAIN: begin
            req_stall  = 1'b1;
            ctrl.shift = load && !load_last;
            ctrl.clear = load && load_last;
            if (load) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Row of slot cells; slot 0 holds the highest score.
   assign found[0] = 1'b0;

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      slot_type prev_slot;
      slot_type next_slot;
      logic     active;

      assign active = i < int'(k_eff);

      if (i == 0) begin : g_first
         assign prev_slot = '0;
      end else begin : g_mid_prev
         assign prev_slot = slots[i-1];
      end

      if (i == K_MAX - 1) begin : g_last
         assign next_slot = '0;
      end else begin : g_mid_next
         assign next_slot = slots[i+1];
      end

      tkst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .active    (active),
         .new_slot  (new_slot),
         .found_in  (found[i]),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .found_out (found[i+1]),
         .slot      (slots[i])
      );
   end

   // Output register, fed from slot 0 during readout.
   always_comb begin
      rsp_in.rank      = cnt_ff[RANK_W-1:0];
      rsp_in.out_score = slots[0].score;
      rsp_in.out_tag   = slots[0].tag;
      rsp_in.last      = load_last;
      rsp_valid_in     = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An end-of-batch request always starts a readout.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.end_of_batch) |=> (state_ff == ST_DRAIN))
      else $error("end of batch did not start readout");

   // The readout count stays below the number of slots in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (cnt_ff < k_eff))
      else $error("readout count overran slots in use");

   // Loading the final result leaves the store cleared.
   assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (slots[0].score == '0 && slots[K_MAX-1].tag == '0))
      else $error("store not cleared after readout");

   // A loaded result carries a last marker exactly when it ends the run.
   assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && (rsp_data.last == (state_ff == ST_IDLE))))
      else $error("last marker disagrees with readout state");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for top_k_score_tracker_core: random and directed
// score requests, ranked readouts checked against an in-bench sorted store.
// Depends on tkst_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
   import tkst_pkg::*;

   // One queued request, optionally held back until all readouts are in.
   typedef struct {
      req_type item;
      bit      hold_for_drain;
   } queued_req;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [K_CFG_W-1:0]   csr_wr_data = '0;

   // Predicted slot row and the configured slot count.
   logic signed [SCORE_W-1:0] held_score [K_MAX];
   logic [TAG_W-1:0]          held_tag [K_MAX];
   logic [K_CFG_W-1:0]        k_setting = K_CFG_W'(1);

   queued_req req_backlog [$];
   rsp_type   pending_ranks [$];
   int        error_count = 0;
   int        idle_cycles = 0;
   bit        calm = 1'b0;

   top_k_score_tracker_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < K_MAX; i++) begin
         held_score[i] = '0;
         held_tag[i] = '0;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else if (roll < 98) return $urandom_range(4, 10);
      else return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 100) begin
         $display("mismatch at %0t: %s got %h, wanted %h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // Insert one accepted request into the sorted row; on end of batch,
   // queue the ranked readout and clear the row.
   task automatic track_score(input req_type r);
      int      used;
      int      spot;
      rsp_type res;
      if (k_setting == '0) used = 1;
      else if (k_setting > K_CFG_W'(K_LIMIT)) used = K_LIMIT;
      else used = int'(k_setting);
      spot = used;
      for (int i = 0; i < used; i++) begin
         if ($signed(r.score) > $signed(held_score[i])) begin
            spot = i;
            break;
         end
      end
      if (spot < used) begin
         for (int i = used - 1; i > spot; i--) begin
            held_score[i] = held_score[i-1];
            held_tag[i] = held_tag[i-1];
         end
         held_score[spot] = r.score;
         held_tag[spot] = r.tag;
      end
      if (r.end_of_batch) begin
         for (int i = 0; i < used; i++) begin
            res.rank = RANK_W'(i);
            res.out_score = held_score[i];
            res.out_tag = held_tag[i];
            res.last = (i == used - 1);
            pending_ranks.push_back(res);
         end
         for (int i = 0; i < K_MAX; i++) begin
            held_score[i] = '0;
            held_tag[i] = '0;
         end
      end
   endtask

   task automatic add_req(input logic [31:0] score, input logic [31:0] tag,
                          input bit eob, input bit hold);
      queued_req q;
      q.item.score = score;
      q.item.tag = tag;
      q.item.end_of_batch = eob;
      q.hold_for_drain = hold;
      req_backlog.push_back(q);
   endtask

   // Settled check at the falling edge so no race with the driver.
   task automatic wait_idle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || pending_ranks.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_k(input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= K_CFG_W'(value);
      k_setting = K_CFG_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Request driver: holds a stalled request, else inserts gaps between items.
   int req_gap = 0;
   always @(posedge clock) begin
      queued_req next_up;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_score(req_data);
         end
         if (req_valid && req_stall) begin
            // The stalled request stays on the port unchanged.
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].hold_for_drain && pending_ranks.size() != 0)) begin
            next_up = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_data <= next_up.item;
            req_gap = calm ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: compares each accepted result with the oldest prediction.
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ranks.size() == 0) begin
               report_mismatch("unexpected result, tag", rsp_data.out_tag, 32'h0);
            end else begin
               want = pending_ranks.pop_front();
               if (rsp_data.rank !== want.rank)
                  report_mismatch("rank", 32'(rsp_data.rank), 32'(want.rank));
               if (rsp_data.out_score !== want.out_score)
                  report_mismatch("out_score", rsp_data.out_score, want.out_score);
               if (rsp_data.out_tag !== want.out_tag)
                  report_mismatch("out_tag", rsp_data.out_tag, want.out_tag);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = calm ? 0 : pick_gap();
         end
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: a directed batch set, then random phases at several slot counts.
   initial begin
      int k_plan [10];
      int made;
      int batch_len;
      logic [31:0] score;
      bit eob;
      k_plan = '{16, 0, 31, 1, 17, 3, 16, 9, 5, 2};
      k_plan[9] = $urandom_range(2, 15);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_k(4);
      // Extremes, scores that never enter, a tie, and overflow of the row.
      add_req(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_req(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_req(32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0);
      add_req(32'h0001_0000, 32'hA000_0001, 1'b0, 1'b0);
      add_req(32'h0001_0000, 32'hA000_0002, 1'b0, 1'b0);
      add_req(32'h0000_0001, 32'hA000_0003, 1'b0, 1'b0);
      add_req(32'h0002_0000, 32'hA000_0004, 1'b0, 1'b0);
      // End of batch with a negative score, then on an empty row.
      add_req(32'hFFFF_FFFF, 32'hA000_0005, 1'b1, 1'b0);
      add_req(32'h0000_0000, 32'h5555_5555, 1'b1, 1'b0);
      add_req(32'h0000_8000, 32'hAAAA_AAAA, 1'b1, 1'b1);
      // Leave entries in the row across a change of slot count.
      add_req(32'h0003_0000, 32'h0BAD_0001, 1'b0, 1'b0);
      add_req(32'h0004_0000, 32'h0BAD_0002, 1'b0, 1'b0);
      wait_idle();
      set_k(1);
      add_req(32'h0005_0000, 32'h0BAD_0003, 1'b0, 1'b0);
      wait_idle();
      set_k(4);
      add_req(32'h0000_0002, 32'h0BAD_0004, 1'b1, 1'b0);

      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         set_k(k_plan[phase]);
         calm = (phase % 4 == 3);
         made = 0;
         while (made < 46) begin
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                    : $urandom_range(1, 12);
            for (int n = 0; n < batch_len && made < 46; n++) begin
               case ($urandom_range(0, 9))
                  0: score = $urandom();
                  1: begin
                     case ($urandom_range(0, 4))
                        0: score = 32'h7FFF_FFFF;
                        1: score = 32'h8000_0000;
                        2: score = 32'h0000_0000;
                        3: score = 32'h0000_0001;
                        default: score = 32'hFFFF_FFFF;
                     endcase
                  end
                  2, 3: score = 32'h0 - 32'($urandom_range(1, 32'h0003_0000));
                  default: begin
                     // Small positive range so equal scores are common.
                     score = 32'($urandom_range(1, 12)) << 16;
                     if ($urandom_range(0, 1)) score = score | 32'($urandom_range(0, 16'hFFFF));
                  end
               endcase
               eob = (n == batch_len - 1) || (made == 45 && phase % 2 == 0);
               add_req(score, $urandom(), eob,
                       (made == 0 && phase == 4) || $urandom_range(0, 39) == 0);
               made++;
            end
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
